### sv/nae_pkg.sv
`timescale 1ns / 1ps
package nae_pkg;

   localparam int HiddenNeuronsDefault = 256;
   localparam int FeatureRowsDefault   = 768;
   localparam logic [5:0] FlipSquare   = 6'd56;

   localparam logic [8:0]  NetworkWidthReset = 9'd256;
   localparam logic [15:0] OutputBiasReset   = 16'd0;
   localparam logic [14:0] ClampMaxReset     = 15'd255;
   localparam logic [9:0]  EvalScaleReset    = 10'd400;
   localparam logic [9:0]  MulScaleReset     = 10'd64;

   localparam logic [2:0] OP_WR_WEIGHT = 3'd0;
   localparam logic [2:0] OP_WR_BIAS   = 3'd1;
   localparam logic [2:0] OP_WR_OUT    = 3'd2;
   localparam logic [2:0] OP_CLEAR     = 3'd3;
   localparam logic [2:0] OP_ADD       = 3'd4;
   localparam logic [2:0] OP_DEL       = 3'd5;
   localparam logic [2:0] OP_MOVE      = 3'd6;
   localparam logic [2:0] OP_EVAL      = 3'd7;

   localparam logic [2:0] REG_NETWORK_WIDTH = 3'd0;
   localparam logic [2:0] REG_OUTPUT_BIAS   = 3'd1;
   localparam logic [2:0] REG_CLAMP_MAX     = 3'd2;
   localparam logic [2:0] REG_EVAL_SCALE    = 3'd3;
   localparam logic [2:0] REG_MUL_SCALE     = 3'd4;

   localparam logic [1:0] MODE_ADD  = 2'd0;
   localparam logic [1:0] MODE_SUB  = 2'd1;
   localparam logic [1:0] MODE_LOAD = 2'd2;
   localparam logic [1:0] MODE_EVAL = 2'd3;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [14:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   function automatic logic [9:0] feature_row(input logic color, input logic [2:0] ptype,
                                              input logic [5:0] sq);
      feature_row = (color ? 10'd384 : 10'd0) + {1'b0, ptype, 6'd0} + {4'd0, sq};
   endfunction

endpackage

### sv/nae_divider.sv
`timescale 1ns / 1ps
module nae_divider
   import nae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  count_ff, count_in;
   logic [31:0] dq_ff, dq_in;
   logic [15:0] rem_ff, rem_in;
   logic [14:0] div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      trial    = {rem_ff[14:0], dq_ff[31]};
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = 6'd0;
         neg_in   = div_req.dividend[31];
         dq_in    = div_req.dividend[31] ? (~div_req.dividend + 32'd1) : div_req.dividend;
         rem_in   = 16'd0;
         div_in   = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            dq_in  = {dq_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            dq_in  = {dq_ff[30:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? (~dq_in + 32'd1) : dq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### sv/nnue_accumulator_evaluator.sv
`timescale 1ns / 1ps
// Sequence: add/delete run a pass over the n used columns; move adds at the square, then
// subtracts at the removed square; clear loads biases over all H columns; table writes run no
// pass; evaluate runs a pass and two divisions before its result beat (n = used network width,
// H = HIDDEN_NEURONS). Throughput: one item at a time; one hidden column per cycle through the
// accumulator memories. Reset: synchronous; a pass over all H columns zeroes biases, output
// weights and accumulators, taking no item meanwhile. Feature weights hold no reset value.
module nnue_accumulator_evaluator
   import nae_pkg::*;
#(
   parameter int HIDDEN_NEURONS = HiddenNeuronsDefault,
   parameter int FEATURE_ROWS   = FeatureRowsDefault
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic        req_color,
   input  logic [2:0]  req_piece_type,
   input  logic [5:0]  req_square,
   input  logic [5:0]  req_removed_square,
   input  logic [9:0]  req_weight_row,
   input  logic [7:0]  req_weight_column,
   input  logic signed [15:0] req_weight_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_score,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IW    = (HIDDEN_NEURONS > 1) ? $clog2(HIDDEN_NEURONS) : 1;
   localparam int CW    = $clog2(HIDDEN_NEURONS + 1);
   localparam int FW_D  = FEATURE_ROWS * HIDDEN_NEURONS;
   localparam int FAW   = $clog2(FW_D);

   localparam logic [3:0] ST_INIT  = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_RUN   = 4'd2;
   localparam logic [3:0] ST_DRAIN = 4'd3;
   localparam logic [3:0] ST_DIV1S = 4'd4;
   localparam logic [3:0] ST_DIV1W = 4'd5;
   localparam logic [3:0] ST_MULS  = 4'd6;
   localparam logic [3:0] ST_DIV2S = 4'd7;
   localparam logic [3:0] ST_DIV2W = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   logic [15:0] fw_mem [FW_D];
   logic [15:0] bias_mem [HIDDEN_NEURONS];
   logic [15:0] ow0_mem [HIDDEN_NEURONS];
   logic [15:0] ow1_mem [HIDDEN_NEURONS];
   logic [15:0] accw_mem [HIDDEN_NEURONS];
   logic [15:0] accb_mem [HIDDEN_NEURONS];

   logic [8:0]  nw_ff;
   logic [15:0] obias_ff;
   logic [14:0] cmax_ff;
   logic [9:0]  escale_ff;
   logic [9:0]  mscale_ff;

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] limit_ff, limit_in;
   logic [1:0]  mode_ff, mode_in;
   logic        move_ff, move_in;
   logic        stm_ff, stm_in;
   logic [9:0]  roww_ff, roww_in, rowb_ff, rowb_in;
   logic        rcolor_ff, rcolor_in;
   logic [2:0]  rtype_ff, rtype_in;
   logic [5:0]  rsq_ff, rsq_in;

   logic [CW-1:0] used_n;
   logic        accept, issue;
   logic        col_ok;
   logic [IW-1:0] wr_col, rd_col;

   logic        fw_we;
   logic [FAW-1:0] fw_wa, fw_ra_w, fw_ra_b;
   logic [15:0] fw_rd_w_ff, fw_rd_b_ff;
   logic        bias_we, ow0_we, ow1_we, acc_we;
   logic [IW-1:0] tab_wa, acc_wa;
   logic [15:0] tab_wd, accw_wd, accb_wd;
   logic [15:0] bias_rd_ff, ow0_rd_ff, ow1_rd_ff, accw_rd_ff, accb_rd_ff;

   logic        s1_valid_ff;
   logic [IW-1:0] s1_col_ff;
   logic        e2_valid_ff, e3_valid_ff, e4_valid_ff;
   logic [14:0] x0_ff, x1_ff;
   logic [15:0] w0_ff, w1_ff, w0b_ff, w1b_ff;
   logic [29:0] c0_ff, c1_ff;
   logic [31:0] p0_ff, p1_ff;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] t_ff, t_in;
   logic        pipe_busy;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_score_ff, rsp_score_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   function automatic logic [14:0] clamp_act(input logic [15:0] x, input logic [14:0] cmax);
      if (x[15])
         clamp_act = 15'd0;
      else if (x[14:0] > cmax)
         clamp_act = cmax;
      else
         clamp_act = x[14:0];
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign used_n    = (32'(nw_ff) > 32'(HIDDEN_NEURONS)) ? CW'(HIDDEN_NEURONS) : CW'(nw_ff);
   assign col_ok    = (int'(req_weight_column) < HIDDEN_NEURONS);
   assign wr_col    = IW'(req_weight_column);
   assign rd_col    = col_ff[IW-1:0];
   assign issue     = (state_ff == ST_RUN) && (col_ff < limit_ff);
   assign pipe_busy = s1_valid_ff || e2_valid_ff || e3_valid_ff || e4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nw_ff     <= NetworkWidthReset;
         obias_ff  <= OutputBiasReset;
         cmax_ff   <= ClampMaxReset;
         escale_ff <= EvalScaleReset;
         mscale_ff <= MulScaleReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_NETWORK_WIDTH: nw_ff     <= csr_data[8:0];
            REG_OUTPUT_BIAS:   obias_ff  <= csr_data;
            REG_CLAMP_MAX:     cmax_ff   <= csr_data[14:0];
            REG_EVAL_SCALE:    escale_ff <= csr_data[9:0];
            REG_MUL_SCALE:     mscale_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // table writes and the reset sweep
   always_comb begin
      fw_we   = accept && (req_op == OP_WR_WEIGHT) && col_ok
                && (int'(req_weight_row) < FEATURE_ROWS);
      fw_wa   = FAW'(FAW'(req_weight_row) * FAW'(HIDDEN_NEURONS) + FAW'(wr_col));
      bias_we = accept && (req_op == OP_WR_BIAS) && col_ok;
      ow0_we  = accept && (req_op == OP_WR_OUT) && col_ok && !req_color;
      ow1_we  = accept && (req_op == OP_WR_OUT) && col_ok && req_color;
      tab_wa  = wr_col;
      tab_wd  = req_weight_value;
      if (state_ff == ST_INIT) begin
         bias_we = 1'b1;
         ow0_we  = 1'b1;
         ow1_we  = 1'b1;
         tab_wa  = rd_col;
         tab_wd  = 16'd0;
      end
      fw_ra_w = FAW'(FAW'(roww_ff) * FAW'(HIDDEN_NEURONS) + FAW'(rd_col));
      fw_ra_b = FAW'(FAW'(rowb_ff) * FAW'(HIDDEN_NEURONS) + FAW'(rd_col));
   end

   // accumulator write-back from stage one
   always_comb begin
      acc_we  = 1'b0;
      acc_wa  = s1_col_ff;
      accw_wd = accw_rd_ff + fw_rd_w_ff;
      accb_wd = accb_rd_ff + fw_rd_b_ff;
      if (state_ff == ST_INIT) begin
         acc_we  = 1'b1;
         acc_wa  = rd_col;
         accw_wd = 16'd0;
         accb_wd = 16'd0;
      end else if (s1_valid_ff) begin
         case (mode_ff)
            MODE_ADD: acc_we = 1'b1;
            MODE_SUB: begin
               acc_we  = 1'b1;
               accw_wd = accw_rd_ff - fw_rd_w_ff;
               accb_wd = accb_rd_ff - fw_rd_b_ff;
            end
            MODE_LOAD: begin
               acc_we  = 1'b1;
               accw_wd = bias_rd_ff;
               accb_wd = bias_rd_ff;
            end
            default: acc_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (fw_we)
         fw_mem[fw_wa] <= req_weight_value;
      fw_rd_w_ff <= fw_mem[fw_ra_w];
      fw_rd_b_ff <= fw_mem[fw_ra_b];
   end

   always_ff @(posedge clock) begin
      if (bias_we)
         bias_mem[tab_wa] <= tab_wd;
      bias_rd_ff <= bias_mem[rd_col];
   end

   always_ff @(posedge clock) begin
      if (ow0_we)
         ow0_mem[tab_wa] <= tab_wd;
      ow0_rd_ff <= ow0_mem[rd_col];
   end

   always_ff @(posedge clock) begin
      if (ow1_we)
         ow1_mem[tab_wa] <= tab_wd;
      ow1_rd_ff <= ow1_mem[rd_col];
   end

   always_ff @(posedge clock) begin
      if (acc_we)
         accw_mem[acc_wa] <= accw_wd;
      accw_rd_ff <= accw_mem[rd_col];
   end

   always_ff @(posedge clock) begin
      if (acc_we)
         accb_mem[acc_wa] <= accb_wd;
      accb_rd_ff <= accb_mem[rd_col];
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      limit_in  = limit_ff;
      mode_in   = mode_ff;
      move_in   = move_ff;
      stm_in    = stm_ff;
      roww_in   = roww_ff;
      rowb_in   = rowb_ff;
      rcolor_in = rcolor_ff;
      rtype_in  = rtype_ff;
      rsq_in    = rsq_ff;
      t_in      = t_ff;
      div_req.start    = 1'b0;
      div_req.dividend = sum_ff;
      div_req.divisor  = (cmax_ff == 15'd0) ? 15'd1 : cmax_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_score_in = rsp_score_ff;
      case (state_ff)
         ST_INIT: begin
            col_in = col_ff + CW'(1);
            if (col_ff == CW'(HIDDEN_NEURONS - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               col_in    = '0;
               move_in   = 1'b0;
               stm_in    = req_color;
               rcolor_in = req_color;
               rtype_in  = req_piece_type;
               rsq_in    = req_removed_square;
               roww_in   = feature_row(req_color, req_piece_type, req_square);
               rowb_in   = feature_row(~req_color, req_piece_type, req_square ^ FlipSquare);
               limit_in  = used_n;
               case (req_op)
                  OP_CLEAR: begin
                     mode_in  = MODE_LOAD;
                     limit_in = CW'(HIDDEN_NEURONS);
                     state_in = ST_RUN;
                  end
                  OP_ADD, OP_DEL, OP_MOVE: begin
                     mode_in = (req_op == OP_DEL) ? MODE_SUB : MODE_ADD;
                     move_in = (req_op == OP_MOVE);
                     if (req_piece_type < 3'd6)
                        state_in = ST_RUN;
                  end
                  OP_EVAL: begin
                     mode_in  = MODE_EVAL;
                     state_in = ST_RUN;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RUN: begin
            if (issue)
               col_in = col_ff + CW'(1);
            else
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               if (move_ff) begin
                  move_in  = 1'b0;
                  mode_in  = MODE_SUB;
                  col_in   = '0;
                  roww_in  = feature_row(rcolor_ff, rtype_ff, rsq_ff);
                  rowb_in  = feature_row(~rcolor_ff, rtype_ff, rsq_ff ^ FlipSquare);
                  state_in = ST_RUN;
               end else if (mode_ff == MODE_EVAL) begin
                  state_in = ST_DIV1S;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV1S: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV1W;
         end
         ST_DIV1W: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quotient + {{16{obias_ff[15]}}, obias_ff};
               state_in = ST_MULS;
            end
         end
         ST_MULS: begin
            t_in     = 32'(t_ff * {22'd0, escale_ff});
            state_in = ST_DIV2S;
         end
         ST_DIV2S: begin
            div_req.start    = 1'b1;
            div_req.dividend = t_ff;
            state_in         = ST_DIV2W;
         end
         ST_DIV2W: begin
            div_req.dividend = t_ff;
            div_req.divisor  = (mscale_ff == 10'd0) ? 15'd1 : {5'd0, mscale_ff};
            if (div_rsp.done) begin
               t_in     = div_rsp.quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = t_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_DIV2S)
         div_req.divisor = (mscale_ff == 10'd0) ? 15'd1 : {5'd0, mscale_ff};
   end

   always_comb begin
      sum_in = sum_ff;
      if (accept)
         sum_in = 32'd0;
      else if (e4_valid_ff)
         sum_in = sum_ff + p0_ff + p1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         col_ff       <= '0;
         move_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         e3_valid_ff  <= 1'b0;
         e4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         move_ff      <= move_in;
         s1_valid_ff  <= issue;
         e2_valid_ff  <= s1_valid_ff && (mode_ff == MODE_EVAL);
         e3_valid_ff  <= e2_valid_ff;
         e4_valid_ff  <= e3_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff     <= limit_in;
      mode_ff      <= mode_in;
      stm_ff       <= stm_in;
      roww_ff      <= roww_in;
      rowb_ff      <= rowb_in;
      rcolor_ff    <= rcolor_in;
      rtype_ff     <= rtype_in;
      rsq_ff       <= rsq_in;
      t_ff         <= t_in;
      sum_ff       <= sum_in;
      rsp_score_ff <= rsp_score_in;
      s1_col_ff    <= rd_col;
      x0_ff  <= clamp_act(stm_ff ? accb_rd_ff : accw_rd_ff, cmax_ff);
      x1_ff  <= clamp_act(stm_ff ? accw_rd_ff : accb_rd_ff, cmax_ff);
      w0_ff  <= ow0_rd_ff;
      w1_ff  <= ow1_rd_ff;
      c0_ff  <= {15'd0, x0_ff} * {15'd0, x0_ff};
      c1_ff  <= {15'd0, x1_ff} * {15'd0, x1_ff};
      w0b_ff <= w0_ff;
      w1b_ff <= w1_ff;
      p0_ff  <= 32'({2'd0, c0_ff} * {{16{w0b_ff[15]}}, w0b_ff});
      p1_ff  <= 32'({2'd0, c1_ff} * {{16{w1b_ff[15]}}, w1b_ff});
   end

   nae_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = rsp_score_ff;

   a_s1_in_pass: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ($past(state_ff) == ST_RUN))
      else $error("column stage active outside a pass");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV1W || state_ff == ST_DIV2W))
      else $error("divider finished while not awaited");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result beat without finished evaluation");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_busy)
      else $error("column pipeline busy while idle");

endmodule

### bench/nnue_accumulator_checker.sv
`timescale 1ns / 1ps
module nnue_accumulator_checker
   import nae_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic               req_color,
   input  logic [2:0]         req_piece_type,
   input  logic [5:0]         req_square,
   input  logic [5:0]         req_removed_square,
   input  logic [9:0]         req_weight_row,
   input  logic [7:0]         req_weight_column,
   input  logic signed [15:0] req_weight_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_score,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output int                 errors,
   output int                 pending,
   output int                 scores_checked
);

   localparam int Neurons = HiddenNeuronsDefault;
   localparam int Rows    = FeatureRowsDefault;

   bit [15:0] feature_table [0:Rows*Neurons-1];
   bit [15:0] bias_table [0:Neurons-1];
   bit [15:0] out_table [0:2*Neurons-1];
   bit [15:0] acc [0:2*Neurons-1];

   bit [8:0]  net_width;
   bit [15:0] out_bias;
   bit [14:0] clamp_max;
   bit [9:0]  score_gain;
   bit [9:0]  score_divisor;

   int expected_scores [$];

   initial begin
      errors = 0;
      pending = 0;
      scores_checked = 0;
   end

   function automatic int active_columns();
      return (net_width > Neurons) ? Neurons : int'(net_width);
   endfunction

   task automatic apply_feature(input bit color, input int ptype, input int sq, input bit sub);
      int row_w;
      int row_b;
      row_w = color * 384 + ptype * 64 + sq;
      row_b = (color ^ 1'b1) * 384 + ptype * 64 + (sq ^ int'(FlipSquare));
      for (int i = 0; i < active_columns(); i++) begin
         if (sub) begin
            acc[i] = acc[i] - feature_table[row_w*Neurons+i];
            acc[Neurons+i] = acc[Neurons+i] - feature_table[row_b*Neurons+i];
         end else begin
            acc[i] = acc[i] + feature_table[row_w*Neurons+i];
            acc[Neurons+i] = acc[Neurons+i] + feature_table[row_b*Neurons+i];
         end
      end
   endtask

   function automatic int weighted_half(input int persp, input int row);
      int total;
      int x;
      int w;
      total = 0;
      for (int i = 0; i < active_columns(); i++) begin
         x = int'($signed(acc[persp*Neurons+i]));
         w = int'($signed(out_table[row*Neurons+i]));
         if (x < 0) x = 0;
         if (x > int'(clamp_max)) x = int'(clamp_max);
         total = total + (x * x) * w;
      end
      return total;
   endfunction

   function automatic int score_for(input bit stm);
      int raw;
      int d1;
      int d2;
      int t;
      raw = weighted_half(stm, 0) + weighted_half(stm ^ 1'b1, 1);
      d1 = (clamp_max == 0) ? 1 : int'(clamp_max);
      d2 = (score_divisor == 0) ? 1 : int'(score_divisor);
      t = raw / d1 + int'($signed(out_bias));
      t = t * int'(score_gain);
      return t / d2;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (bias_table[i]) bias_table[i] = '0;
         foreach (out_table[i]) out_table[i] = '0;
         foreach (acc[i]) acc[i] = '0;
         net_width = NetworkWidthReset;
         out_bias = OutputBiasReset;
         clamp_max = ClampMaxReset;
         score_gain = EvalScaleReset;
         score_divisor = MulScaleReset;
         expected_scores.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_NETWORK_WIDTH: net_width = csr_data[8:0];
               REG_OUTPUT_BIAS:   out_bias = csr_data;
               REG_CLAMP_MAX:     clamp_max = csr_data[14:0];
               REG_EVAL_SCALE:    score_gain = csr_data[9:0];
               REG_MUL_SCALE:     score_divisor = csr_data[9:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               $error("score beat with nothing expected: actual %0d", rsp_score);
               errors++;
            end else begin
               if (rsp_score !== expected_scores[0]) begin
                  $error("score mismatch: expected %0d actual %0d",
                         expected_scores[0], rsp_score);
                  errors++;
               end
               void'(expected_scores.pop_front());
               scores_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            case (req_op)
               OP_WR_WEIGHT:
                  if (req_weight_row < Rows)
                     feature_table[int'(req_weight_row)*Neurons+int'(req_weight_column)] =
                        req_weight_value;
               OP_WR_BIAS: bias_table[req_weight_column] = req_weight_value;
               OP_WR_OUT: out_table[int'(req_color)*Neurons+int'(req_weight_column)] =
                  req_weight_value;
               OP_CLEAR:
                  for (int i = 0; i < Neurons; i++) begin
                     acc[i] = bias_table[i];
                     acc[Neurons+i] = bias_table[i];
                  end
               OP_ADD:
                  if (req_piece_type < 6)
                     apply_feature(req_color, req_piece_type, req_square, 1'b0);
               OP_DEL:
                  if (req_piece_type < 6)
                     apply_feature(req_color, req_piece_type, req_square, 1'b1);
               OP_MOVE:
                  if (req_piece_type < 6) begin
                     apply_feature(req_color, req_piece_type, req_square, 1'b0);
                     apply_feature(req_color, req_piece_type, req_removed_square, 1'b1);
                  end
               default: expected_scores.push_back(score_for(req_color));
            endcase
         end
      end
      pending = expected_scores.size();
   end

endmodule

### bench/nnue_accumulator_evaluator_test.sv
`timescale 1ns / 1ps
module nnue_accumulator_evaluator_test;
   import nae_pkg::*;

   localparam int Neurons    = HiddenNeuronsDefault;
   localparam int DrainWait  = 2 * Neurons + 90;
   localparam int CycleLimit = 5000000;
   localparam int ChunkItems = 16;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_op = OP_CLEAR;
   logic               req_color = 1'b0;
   logic [2:0]         req_piece_type = '0;
   logic [5:0]         req_square = '0;
   logic [5:0]         req_removed_square = '0;
   logic [9:0]         req_weight_row = '0;
   logic [7:0]         req_weight_column = '0;
   logic signed [15:0] req_weight_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_score;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = REG_NETWORK_WIDTH;
   logic [15:0]        csr_data = '0;

   int errors;
   int pending;
   int scores_checked;
   int cycles = 0;
   int items_sent = 0;
   int settings_used = 0;
   int burst_left = 0;
   int used_width = Neurons;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int stall_mode = 0;
   bit written [0:FeatureRowsDefault-1][0:Neurons-1];

   nnue_accumulator_evaluator u_dut (.*);

   nnue_accumulator_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 1500;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic send(input logic [2:0] op, input int color, input int ptype, input int sq,
                       input int rsq, input int row, input int col, input int val);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_color <= 1'(color);
      req_piece_type <= 3'(ptype);
      req_square <= 6'(sq);
      req_removed_square <= 6'(rsq);
      req_weight_row <= 10'(row);
      req_weight_column <= 8'(col);
      req_weight_value <= 16'(val);
      do @(posedge clock); while (req_stall);
      if (op == OP_WR_WEIGHT && row < FeatureRowsDefault) written[row][col] = 1'b1;
      burst_left--;
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= 16'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int nw, input int ob, input int cm, input int es,
                                input int ms);
      settle();
      write_reg(REG_NETWORK_WIDTH, nw);
      write_reg(REG_OUTPUT_BIAS, ob);
      write_reg(REG_CLAMP_MAX, cm);
      write_reg(REG_EVAL_SCALE, es);
      write_reg(REG_MUL_SCALE, ms);
      used_width = (nw % 512 > Neurons) ? Neurons : nw % 512;
      settings_used++;
   endtask

   function automatic bit feature_ready(input int color, input int ptype, input int sq);
      int row_w;
      int row_b;
      row_w = color * 384 + ptype * 64 + sq;
      row_b = (color ^ 1) * 384 + ptype * 64 + (sq ^ int'(FlipSquare));
      for (int i = 0; i < used_width; i++)
         if (!written[row_w][i] || !written[row_b][i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int pick_square(input int color, input int ptype);
      int sq;
      for (int k = 0; k < 8; k++) begin
         sq = $urandom_range(0, 63);
         if (feature_ready(color, ptype, sq)) return sq;
      end
      for (sq = 0; sq < 64; sq++)
         if (feature_ready(color, ptype, sq)) return sq;
      return -1;
   endfunction

   task automatic random_update(input logic [2:0] op);
      int color;
      int ptype;
      int sq;
      int rsq;
      color = $urandom_range(0, 1);
      ptype = $urandom_range(0, 5);
      if ($urandom_range(0, 9) == 0) begin
         send(op, color, $urandom_range(6, 7), $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 65535));
      end else begin
         sq = pick_square(color, ptype);
         if (sq < 0) begin
            color = 0;
            ptype = 0;
            sq = 0;
         end
         rsq = pick_square(color, ptype);
         if (rsq < 0) rsq = sq;
         send(op, color, ptype, sq, rsq, $urandom_range(0, 1023), $urandom_range(0, 255),
              $urandom_range(0, 65535));
      end
   endtask

   task automatic random_item();
      int pick;
      int row;
      pick = $urandom_range(0, 99);
      row = ($urandom_range(0, 7) == 0) ? $urandom_range(768, 1023) : $urandom_range(0, 767);
      if (pick < 10)
         send(OP_WR_WEIGHT, $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 63),
              $urandom_range(0, 63), row, $urandom_range(0, 255), $urandom_range(0, 65535));
      else if (pick < 18)
         send(OP_WR_BIAS, $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 63),
              $urandom_range(0, 63), row, $urandom_range(0, 255),
              $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 600));
      else if (pick < 26)
         send(OP_WR_OUT, $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 63),
              $urandom_range(0, 63), row, $urandom_range(0, 255), $urandom_range(0, 65535));
      else if (pick < 31)
         send(OP_CLEAR, $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 63),
              $urandom_range(0, 63), row, $urandom_range(0, 255), $urandom_range(0, 65535));
      else if (pick < 51) random_update(OP_ADD);
      else if (pick < 66) random_update(OP_DEL);
      else if (pick < 80) random_update(OP_MOVE);
      else
         send(OP_EVAL, $urandom_range(0, 1), $urandom_range(0, 7), $urandom_range(0, 63),
              $urandom_range(0, 63), row, $urandom_range(0, 255), $urandom_range(0, 65535));
   endtask

   int fixed_settings [6][5] = '{
      '{0, 32767, 32767, 1, 1023},
      '{5, -32768, 1, 1023, 1},
      '{511, 100, 255, 400, 64},
      '{256, -1, 0, 0, 0},
      '{16, 0, 1, 1023, 1},
      '{32, 1234, 300, 77, 3}
   };
   int pool_squares [2] = '{0, 56};

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load a small pool of features for 16 columns, two of them at full width
      apply_setting(16, 0, 255, 400, 64);
      for (int c = 0; c < 2; c++)
         for (int t = 0; t < 6; t++)
            foreach (pool_squares[s])
               for (int col = 0; col < 16; col++)
                  send(OP_WR_WEIGHT, c, t, 0, 0, c * 384 + t * 64 + pool_squares[s], col,
                       $urandom_range(0, 65535));
      for (int col = 16; col < Neurons; col++) begin
         send(OP_WR_WEIGHT, 0, 0, 0, 0, 0, col, $urandom_range(0, 65535));
         send(OP_WR_WEIGHT, 1, 0, 0, 0, 440, col, $urandom_range(0, 65535));
      end

      send(OP_WR_BIAS, 0, 0, 0, 0, 0, 0, 32767);
      send(OP_WR_BIAS, 0, 0, 0, 0, 0, 1, -32768);
      send(OP_WR_BIAS, 0, 0, 0, 0, 0, 255, 200);
      send(OP_WR_OUT, 0, 0, 0, 0, 0, 0, 32767);
      send(OP_WR_OUT, 1, 0, 0, 0, 0, 0, -32768);
      send(OP_WR_OUT, 1, 0, 0, 0, 0, 255, 513);
      send(OP_WR_WEIGHT, 0, 0, 0, 0, 800, 3, 1);
      send(OP_WR_WEIGHT, 1, 7, 63, 63, 1023, 255, -1);
      send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      send(OP_EVAL, 0, 0, 0, 0, 0, 0, 0);
      send(OP_EVAL, 1, 0, 0, 0, 0, 0, 0);
      send(OP_ADD, 0, 0, 0, 0, 0, 0, 0);
      send(OP_ADD, 1, 5, 56, 0, 0, 0, 0);
      send(OP_MOVE, 0, 3, 0, 56, 0, 0, 0);
      send(OP_DEL, 1, 5, 56, 0, 0, 0, 0);
      send(OP_ADD, 0, 7, 63, 0, 0, 0, 0);
      send(OP_MOVE, 1, 6, 12, 34, 0, 0, 0);
      send(OP_DEL, 1, 0, 56, 0, 0, 0, 0);
      send(OP_EVAL, 0, 7, 63, 63, 1023, 255, -1);
      send(OP_EVAL, 1, 0, 0, 0, 0, 0, 0);

      for (int p = 0; p < 9; p++) begin
         if (p < 6)
            apply_setting(fixed_settings[p][0], fixed_settings[p][1], fixed_settings[p][2],
                          fixed_settings[p][3], fixed_settings[p][4]);
         else
            apply_setting($urandom_range(0, 2) ? 16 : 16 * $urandom_range(1, 16),
                          $urandom_range(0, 65535), $urandom_range(1, 32767),
                          $urandom_range(1, 1023), $urandom_range(1, 1023));
         if (p == 0) begin
            // hold the result side while offering items so the block backs up
            hold_request = 1'b1;
            send(OP_EVAL, 0, 0, 0, 0, 0, 0, 0);
            send(OP_EVAL, 1, 0, 0, 0, 0, 0, 0);
         end
         for (int k = 0; k < ChunkItems; k++) random_item();
      end

      settle();
      $display("Sent %0d items across %0d register settings; %0d scores compared.",
               items_sent, settings_used, scores_checked);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
